@@ hw/rtl/bucket_priority_queue_unit_assert.svh @@
// assertion macros for the bucket priority queue unit
// used by the rtl files in this folder; no other dependencies
`ifndef BUCKET_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define BUCKET_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define BPQ_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define BPQ_ASSERT(label, prop, msg)
`define BPQ_ASSERT_NEXT(label, cond, prop, msg)
`endif
`endif

@@ hw/rtl/bpq_pkg.sv @@
// shared types and constants of the bucket priority queue unit
// no dependencies; imported by bpq_min_scan and bucket_priority_queue_unit
package bpq_pkg;

    localparam int KEY_W    = 8;
    localparam int PAY_W    = 32;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 11;
    localparam int MIN_W    = 9;
    localparam int GRP_BITS = 4;
    localparam int GRP_W    = 1 << GRP_BITS;

    localparam logic FN_PUSH = 1'b0;
    localparam logic FN_POP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED = 3'd0,
        ST_POPPED = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_FULL   = 3'd3,
        ST_BADKEY = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP1,
        S_STEP2,
        S_SCAN,
        S_WAIT
    } t_state;

endpackage

@@ hw/rtl/bpq_min_scan.sv @@
// two-stage search for the lowest set bit of the bucket occupancy map
// depends on bpq_pkg and bucket_priority_queue_unit_assert.svh
`include "bucket_priority_queue_unit_assert.svh"
module bpq_min_scan #(
    parameter int NUM_KEYS = 256,
    parameter int BW       = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_KEYS-1:0] i_occ,
    output logic                o_done,
    output logic [BW-1:0]       o_min
);
    import bpq_pkg::*;

    localparam int NGRP = (NUM_KEYS + GRP_W - 1) / GRP_W;
    localparam int GIW  = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int PADW = NGRP * GRP_W;

    logic [PADW-1:0]     occ_pad;
    logic                grp_hit;
    logic [GIW-1:0]      grp_sel;
    logic [GRP_W-1:0]    grp_word;
    logic [GRP_BITS-1:0] bit_sel;

    logic                r_v1;
    logic                r_hit1;
    logic [GIW-1:0]      r_grp;
    logic [GRP_W-1:0]    r_word;
    logic                r_done;
    logic [BW-1:0]       r_min;

    assign occ_pad = PADW'(i_occ);

    // stage 1: first group with any occupied bucket
    always_comb begin
        grp_hit = 1'b0;
        grp_sel = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (|occ_pad[g*GRP_W +: GRP_W]) begin
                grp_hit = 1'b1;
                grp_sel = GIW'(g);
            end
        end
        grp_word = occ_pad[grp_sel*GRP_W +: GRP_W];
    end

    // stage 2: first bucket inside that group
    always_comb begin
        bit_sel = '0;
        for (int b = GRP_W - 1; b >= 0; b--) begin
            if (r_word[b]) begin
                bit_sel = GRP_BITS'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_done <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hit1 <= grp_hit;
            r_grp  <= grp_sel;
            r_word <= grp_word;
        end
        if (r_v1) begin
            r_min <= r_hit1 ? BW'({r_grp, bit_sel}) : BW'(NUM_KEYS);
        end
    end

    assign o_done = r_done;
    assign o_min  = r_min;

    `BPQ_ASSERT_NEXT(a_scan_stage, r_v1, r_done, "scan stage 2 did not follow stage 1")
    `BPQ_ASSERT(a_scan_done_src, r_done |-> $past(r_v1), "scan done without stage 1")
    `BPQ_ASSERT(a_scan_no_overlap, i_start |-> (!r_v1 && !r_done), "scan restarted in flight")

endmodule

@@ hw/rtl/bucket_priority_queue_unit.sv @@
// Bucket priority queue: one FIFO of payloads per key, popped lowest key first.
// A push, a rejected push and an empty pop all finish in the step-one state.
// A pop that finds an entry reads the bucket head, reads the slot payload
// and link, writes back, runs a two-stage search of the occupancy bitmap
// for the new minimum key, then shows the result. No new start is taken
// while busy. State lives in single-port-read synchronous memories for
// payloads, slot links and bucket head and tail pointers, plus one
// occupancy bit per key. Each result appears for one cycle with o_valid;
// the receiver cannot stall it.
// depends on bpq_pkg, bpq_min_scan and bucket_priority_queue_unit_assert.svh
`include "bucket_priority_queue_unit_assert.svh"
module bucket_priority_queue_unit #(
    parameter int NUM_KEYS     = 256,
    parameter int CAPACITY     = 1024,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_func,
    input  logic [bpq_pkg::KEY_W-1:0]     i_key,
    input  logic [bpq_pkg::PAY_W-1:0]     i_payload,
    output logic                          o_valid,
    output logic [bpq_pkg::STATUS_W-1:0]  o_status,
    output logic [bpq_pkg::KEY_W-1:0]     o_out_key,
    output logic [bpq_pkg::PAY_W-1:0]     o_out_payload,
    output logic [bpq_pkg::CNT_W-1:0]     o_entry_count,
    output logic [bpq_pkg::MIN_W-1:0]     o_min_key
);
    import bpq_pkg::*;

    localparam int KIW = $clog2(NUM_KEYS);
    localparam int BW  = $clog2(NUM_KEYS + 1);
    localparam int SW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int XW  = KIW + KEY_W;

    // state and holding registers
    t_state                  r_state, n_state;
    logic                    r_func, n_func;
    logic [KEY_W-1:0]        r_key, n_key;
    logic [PAYLOAD_BITS-1:0] r_payload, n_payload;
    logic [SW-1:0]           r_free_head, n_free_head;
    logic [CW-1:0]           r_fresh, n_fresh;
    logic [CW-1:0]           r_total, n_total;
    logic [BW-1:0]           r_best, n_best;
    logic [NUM_KEYS-1:0]     r_occ, n_occ;
    logic [SW-1:0]           r_slot, n_slot;
    logic                    r_single, n_single;

    logic                    r_o_valid, n_o_valid;
    t_status                 r_o_status, n_o_status;
    logic [KEY_W-1:0]        r_o_key, n_o_key;
    logic [PAY_W-1:0]        r_o_payload, n_o_payload;
    logic [CNT_W-1:0]        r_o_count, n_o_count;
    logic [MIN_W-1:0]        r_o_min, n_o_min;

    // memories
    logic [PAYLOAD_BITS-1:0] r_pay_mem  [CAPACITY];
    logic [SW-1:0]           r_link_mem [CAPACITY];
    logic [SW-1:0]           r_head_mem [NUM_KEYS];
    logic [SW-1:0]           r_tail_mem [NUM_KEYS];
    logic [PAYLOAD_BITS-1:0] r_pay_q;
    logic [SW-1:0]           r_link_q;
    logic [SW-1:0]           r_head_q;
    logic [SW-1:0]           r_tail_q;

    logic                    pay_we, link_we, head_we, tail_we;
    logic [SW-1:0]           pay_wa, link_wa, link_wd, head_wd, tail_wd;
    logic [KIW-1:0]          head_wa, tail_wa;
    logic [PAYLOAD_BITS-1:0] pay_wd;
    logic [SW-1:0]           pay_ra, link_ra;
    logic [KIW-1:0]          head_ra, tail_ra;

    logic [XW-1:0]           key_x, i_key_x;
    logic [KIW-1:0]          kidx, bidx;
    logic                    key_ok, full, use_free;
    logic [SW-1:0]           new_slot;

    logic                    scan_start;
    logic                    scan_done;
    logic [BW-1:0]           scan_min;

    assign key_x    = XW'(r_key);
    assign i_key_x  = XW'(i_key);
    assign kidx     = key_x[KIW-1:0];
    assign bidx     = r_best[KIW-1:0];
    assign key_ok   = key_x < XW'(NUM_KEYS);
    assign full     = r_total == CW'(CAPACITY);
    assign use_free = r_fresh > r_total;
    assign new_slot = use_free ? r_free_head : r_fresh[SW-1:0];

    // read addresses: bucket pointers and free-list link at accept,
    // slot payload and link in the next cycle on a pop
    assign head_ra = bidx;
    assign tail_ra = (i_func == FN_PUSH) ? i_key_x[KIW-1:0] : bidx;
    assign link_ra = (r_state == S_IDLE) ? r_free_head : r_head_q;
    assign pay_ra  = r_head_q;

    assign busy = r_state != S_IDLE;

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_key       = r_key;
        n_payload   = r_payload;
        n_free_head = r_free_head;
        n_fresh     = r_fresh;
        n_total     = r_total;
        n_best      = r_best;
        n_occ       = r_occ;
        n_slot      = r_slot;
        n_single    = r_single;
        n_o_valid   = 1'b0;
        n_o_status  = r_o_status;
        n_o_key     = r_o_key;
        n_o_payload = r_o_payload;
        n_o_count   = r_o_count;
        n_o_min     = r_o_min;
        pay_we      = 1'b0;
        pay_wa      = new_slot;
        pay_wd      = r_payload;
        link_we     = 1'b0;
        link_wa     = r_tail_q;
        link_wd     = new_slot;
        head_we     = 1'b0;
        head_wa     = kidx;
        head_wd     = new_slot;
        tail_we     = 1'b0;
        tail_wa     = kidx;
        tail_wd     = new_slot;
        scan_start  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_func    = i_func;
                    n_key     = i_key;
                    n_payload = PAYLOAD_BITS'(i_payload);
                    n_state   = S_STEP1;
                end
            end
            S_STEP1: begin
                n_o_key     = '0;
                n_o_payload = '0;
                n_o_count   = CNT_W'(r_total);
                n_o_min     = MIN_W'(r_best);
                if (r_func == FN_POP) begin
                    if (r_total == '0) begin
                        n_o_valid  = 1'b1;
                        n_o_status = ST_EMPTY;
                        n_state    = S_IDLE;
                    end else begin
                        n_slot   = r_head_q;
                        n_single = r_head_q == r_tail_q;
                        n_state  = S_STEP2;
                    end
                end else begin
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                    if (!key_ok) begin
                        n_o_status = ST_BADKEY;
                    end else if (full) begin
                        n_o_status = ST_FULL;
                    end else begin
                        pay_we  = 1'b1;
                        tail_we = 1'b1;
                        if (r_occ[kidx]) begin
                            link_we = 1'b1;
                        end else begin
                            head_we = 1'b1;
                        end
                        if (use_free) begin
                            n_free_head = r_link_q;
                        end else begin
                            n_fresh = r_fresh + 1'b1;
                        end
                        n_occ[kidx] = 1'b1;
                        n_total     = r_total + 1'b1;
                        if (BW'(kidx) < r_best) begin
                            n_best = BW'(kidx);
                        end
                        n_o_status = ST_PUSHED;
                        n_o_count  = CNT_W'(n_total);
                        n_o_min    = MIN_W'(n_best);
                    end
                end
            end
            S_STEP2: begin
                n_o_key     = KEY_W'(r_best);
                n_o_payload = PAY_W'(r_pay_q);
                if (r_single) begin
                    n_occ[bidx] = 1'b0;
                end else begin
                    head_we = 1'b1;
                    head_wa = bidx;
                    head_wd = r_link_q;
                end
                // freed slot goes on top of the free list
                link_we     = 1'b1;
                link_wa     = r_slot;
                link_wd     = r_free_head;
                n_free_head = r_slot;
                n_total     = r_total - 1'b1;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                scan_start = 1'b1;
                n_state    = S_WAIT;
            end
            S_WAIT: begin
                if (scan_done) begin
                    n_best     = scan_min;
                    n_o_valid  = 1'b1;
                    n_o_status = ST_POPPED;
                    n_o_count  = CNT_W'(r_total);
                    n_o_min    = MIN_W'(scan_min);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= '0;
            r_fresh     <= '0;
            r_total     <= '0;
            r_best      <= BW'(NUM_KEYS);
            r_occ       <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_fresh     <= n_fresh;
            r_total     <= n_total;
            r_best      <= n_best;
            r_occ       <= n_occ;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_key       <= n_key;
        r_payload   <= n_payload;
        r_slot      <= n_slot;
        r_single    <= n_single;
        r_o_status  <= n_o_status;
        r_o_key     <= n_o_key;
        r_o_payload <= n_o_payload;
        r_o_count   <= n_o_count;
        r_o_min     <= n_o_min;
    end

    always_ff @(posedge i_clk) begin
        if (pay_we) begin
            r_pay_mem[pay_wa] <= pay_wd;
        end
        r_pay_q <= r_pay_mem[pay_ra];
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[link_wa] <= link_wd;
        end
        r_link_q <= r_link_mem[link_ra];
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_head_mem[head_wa] <= head_wd;
        end
        r_head_q <= r_head_mem[head_ra];
    end

    always_ff @(posedge i_clk) begin
        if (tail_we) begin
            r_tail_mem[tail_wa] <= tail_wd;
        end
        r_tail_q <= r_tail_mem[tail_ra];
    end

    bpq_min_scan #(
        .NUM_KEYS (NUM_KEYS),
        .BW       (BW)
    ) u_min_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_occ   (r_occ),
        .o_done  (scan_done),
        .o_min   (scan_min)
    );

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_out_key     = r_o_key;
    assign o_out_payload = r_o_payload;
    assign o_entry_count = r_o_count;
    assign o_min_key     = r_o_min;

    `BPQ_ASSERT(a_strobe_idle, o_valid |-> !busy, "result strobe while busy")
    `BPQ_ASSERT(a_total_cap, r_total <= CW'(CAPACITY), "entry count above capacity")
    `BPQ_ASSERT(a_occ_total, (r_total == '0) == (r_occ == '0), "occupancy map disagrees with count")
    `BPQ_ASSERT(a_fresh_total, r_fresh >= r_total, "fresh slot count below entry count")
    `BPQ_ASSERT(a_best_empty, (r_state == S_IDLE && r_total == '0) |-> (r_best == BW'(NUM_KEYS)), "min key not cleared when empty")
    `BPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "transaction accepted but not busy")

endmodule

@@ sim/bucket_priority_queue_unit_tb.sv @@
// self-checking testbench of bucket_priority_queue_unit: pushes and pops with bursty start
// a scoreboard class predicts every result and checks it against the o_valid strobe
// depends on bpq_pkg and the bucket_priority_queue_unit rtl
localparam int QUEUE_KEYS  = 256;
localparam int QUEUE_SLOTS = 1024;

typedef struct {
    bpq_pkg::t_status              status;
    logic [bpq_pkg::KEY_W-1:0]     out_key;
    logic [bpq_pkg::PAY_W-1:0]     out_payload;
    logic [bpq_pkg::CNT_W-1:0]     entry_count;
    logic [bpq_pkg::MIN_W-1:0]     min_key;
} t_queue_result;

class bucket_queue_checker;
    logic [bpq_pkg::PAY_W-1:0] slot_data [QUEUE_SLOTS];
    int slot_next [QUEUE_SLOTS];
    int free_slots [QUEUE_SLOTS];
    int free_top;
    int bucket_first [QUEUE_KEYS];
    int bucket_last [QUEUE_KEYS];
    int bucket_count [QUEUE_KEYS];
    int held;
    int errors;
    int status_seen [5];
    t_queue_result pending_results [$];

    function new();
        for (int i = 0; i < QUEUE_SLOTS; i++) begin
            free_slots[i] = i;
            slot_next[i] = 0;
            slot_data[i] = '0;
        end
        for (int k = 0; k < QUEUE_KEYS; k++) begin
            bucket_first[k] = 0;
            bucket_last[k] = 0;
            bucket_count[k] = 0;
        end
        for (int i = 0; i < 5; i++) status_seen[i] = 0;
        free_top = QUEUE_SLOTS;
        held = 0;
        errors = 0;
    endfunction

    function int lowest_key();
        for (int k = 0; k < QUEUE_KEYS; k++) begin
            if (bucket_count[k] != 0) return k;
        end
        return QUEUE_KEYS;
    endfunction

    function void record_request(logic func, logic [bpq_pkg::KEY_W-1:0] key,
                                 logic [bpq_pkg::PAY_W-1:0] payload);
        t_queue_result r;
        int k;
        int s;
        r.out_key = '0;
        r.out_payload = '0;
        if (func == bpq_pkg::FN_PUSH) begin
            k = key;
            if (k >= QUEUE_KEYS) begin
                r.status = bpq_pkg::ST_BADKEY;
            end else if (held >= QUEUE_SLOTS) begin
                r.status = bpq_pkg::ST_FULL;
            end else begin
                free_top--;
                s = free_slots[free_top];
                slot_data[s] = payload;
                if (bucket_count[k] == 0) bucket_first[k] = s;
                else slot_next[bucket_last[k]] = s;
                bucket_last[k] = s;
                bucket_count[k]++;
                held++;
                r.status = bpq_pkg::ST_PUSHED;
            end
        end else begin
            if (held == 0) begin
                r.status = bpq_pkg::ST_EMPTY;
            end else begin
                k = lowest_key();
                s = bucket_first[k];
                r.out_key = bpq_pkg::KEY_W'(k);
                r.out_payload = slot_data[s];
                bucket_count[k]--;
                if (bucket_count[k] != 0) bucket_first[k] = slot_next[s];
                free_slots[free_top] = s;
                free_top++;
                held--;
                r.status = bpq_pkg::ST_POPPED;
            end
        end
        r.entry_count = bpq_pkg::CNT_W'(held);
        r.min_key = bpq_pkg::MIN_W'(lowest_key());
        status_seen[r.status]++;
        pending_results.insert(pending_results.size(), r);
    endfunction

    function void check_response(logic [bpq_pkg::STATUS_W-1:0] status,
                                 logic [bpq_pkg::KEY_W-1:0] out_key,
                                 logic [bpq_pkg::PAY_W-1:0] out_payload,
                                 logic [bpq_pkg::CNT_W-1:0] entry_count,
                                 logic [bpq_pkg::MIN_W-1:0] min_key);
        t_queue_result exp;
        if (pending_results.size() == 0) begin
            $error("result strobe with no transaction pending");
            errors++;
            return;
        end
        exp = pending_results[0];
        pending_results.delete(0);
        if (status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, status);
            errors++;
        end
        if (out_key !== exp.out_key) begin
            $error("out_key: expected %0d, got %0d", exp.out_key, out_key);
            errors++;
        end
        if (out_payload !== exp.out_payload) begin
            $error("out_payload: expected %h, got %h", exp.out_payload, out_payload);
            errors++;
        end
        if (entry_count !== exp.entry_count) begin
            $error("entry_count: expected %0d, got %0d", exp.entry_count, entry_count);
            errors++;
        end
        if (min_key !== exp.min_key) begin
            $error("min_key: expected %0d, got %0d", exp.min_key, min_key);
            errors++;
        end
    endfunction
endclass

module bucket_priority_queue_unit_tb;
    localparam int IDLE_LIMIT = 4000;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic                         i_func;
    logic [bpq_pkg::KEY_W-1:0]    i_key;
    logic [bpq_pkg::PAY_W-1:0]    i_payload;
    logic                         o_valid;
    logic [bpq_pkg::STATUS_W-1:0] o_status;
    logic [bpq_pkg::KEY_W-1:0]    o_out_key;
    logic [bpq_pkg::PAY_W-1:0]    o_out_payload;
    logic [bpq_pkg::CNT_W-1:0]    o_entry_count;
    logic [bpq_pkg::MIN_W-1:0]    o_min_key;

    bucket_queue_checker sb;
    int accept_cnt = 0;
    int result_cnt = 0;
    int idle_cycles = 0;
    int burst_left = 0;

    bucket_priority_queue_unit #(
        .NUM_KEYS     (QUEUE_KEYS),
        .CAPACITY     (QUEUE_SLOTS),
        .PAYLOAD_BITS (32)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_out_key     (o_out_key),
        .o_out_payload (o_out_payload),
        .o_entry_count (o_entry_count),
        .o_min_key     (o_min_key)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            sb.record_request(i_func, i_key, i_payload);
            accept_cnt++;
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (i_rst_n && o_valid) begin
            sb.check_response(o_status, o_out_key, o_out_payload, o_entry_count, o_min_key);
            result_cnt++;
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(negedge i_clk);
        $display("bucket_priority_queue_unit_tb NOT OK");
        $finish;
    end

    task automatic send_item(input logic func, input logic [bpq_pkg::KEY_W-1:0] key,
                             input logic [bpq_pkg::PAY_W-1:0] payload);
        int seen_accepts;
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(12, 1)) @(negedge i_clk);
            burst_left = ($urandom_range(9, 0) == 0) ? 200 : $urandom_range(30, 1);
        end
        burst_left--;
        seen_accepts = accept_cnt;
        start <= 1'b1;
        i_func <= func;
        i_key <= key;
        i_payload <= payload;
        do @(negedge i_clk); while (accept_cnt == seen_accepts);
    endtask

    function automatic logic [bpq_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(9, 0))
            0: return '0;
            1: return '1;
            2, 3, 4: return bpq_pkg::KEY_W'($urandom_range(255, 0));
            default: return bpq_pkg::KEY_W'($urandom_range(7, 0));
        endcase
    endfunction

    function automatic logic [bpq_pkg::PAY_W-1:0] pick_payload();
        case ($urandom_range(15, 0))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(input int push_pct);
        if ($urandom_range(99, 0) < push_pct) send_item(bpq_pkg::FN_PUSH, pick_key(), pick_payload());
        else send_item(bpq_pkg::FN_POP, pick_key(), pick_payload());
    endtask

    initial begin
        int empties_hit;
        int guard;
        sb = new();
        i_rst_n = 1'b0;
        start = 1'b0;
        i_func = bpq_pkg::FN_PUSH;
        i_key = '0;
        i_payload = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty pops, key extremes, fifo order within a key
        send_item(bpq_pkg::FN_POP, 8'd0, 32'h0);
        send_item(bpq_pkg::FN_PUSH, 8'd0, 32'h0000_0000);
        send_item(bpq_pkg::FN_PUSH, 8'd255, 32'hffff_ffff);
        send_item(bpq_pkg::FN_PUSH, 8'd255, 32'h0000_0001);
        send_item(bpq_pkg::FN_PUSH, 8'd0, 32'h0000_0002);
        send_item(bpq_pkg::FN_PUSH, 8'd128, 32'h8000_0000);
        repeat (5) send_item(bpq_pkg::FN_POP, 8'hff, 32'hffff_ffff);
        send_item(bpq_pkg::FN_POP, 8'd0, 32'h0);
        send_item(bpq_pkg::FN_PUSH, 8'd5, 32'h1234_5678);
        send_item(bpq_pkg::FN_PUSH, 8'd3, 32'h5555_aaaa);
        send_item(bpq_pkg::FN_PUSH, 8'd5, 32'haaaa_5555);
        send_item(bpq_pkg::FN_PUSH, 8'd1, 32'hdead_beef);
        repeat (5) send_item(bpq_pkg::FN_POP, 8'd0, 32'h0);

        repeat (200) send_random(60);

        // push-heavy stretch builds a deep queue, then drain past empty
        repeat (250) begin
            if ($urandom_range(9, 0) == 0) begin
                send_item(bpq_pkg::FN_POP, pick_key(), pick_payload());
            end else begin
                send_item(bpq_pkg::FN_PUSH, pick_key(), pick_payload());
            end
        end
        empties_hit = 0;
        guard = 0;
        while (empties_hit < 4 && guard < 1000) begin
            if ($urandom_range(9, 0) == 0) begin
                send_item(bpq_pkg::FN_PUSH, pick_key(), pick_payload());
            end else begin
                if (sb.held == 0) empties_hit++;
                send_item(bpq_pkg::FN_POP, pick_key(), pick_payload());
            end
            guard++;
        end

        repeat (60) send_random(50);

        start <= 1'b0;
        while (sb.pending_results.size() > 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);

        $display("ran %0d transactions with %0d results checked", accept_cnt, result_cnt);
        $display("  %0d pushes, %0d pops, %0d empty pops, %0d pushes into a full store",
                 sb.status_seen[bpq_pkg::ST_PUSHED], sb.status_seen[bpq_pkg::ST_POPPED],
                 sb.status_seen[bpq_pkg::ST_EMPTY], sb.status_seen[bpq_pkg::ST_FULL]);
        if (sb.errors == 0) begin
            $display("bucket_priority_queue_unit_tb OK");
        end else begin
            $display("bucket_priority_queue_unit_tb NOT OK");
        end
        $finish;
    end
endmodule

@@ bucket_priority_queue_unit.f @@
+incdir+hw/rtl
hw/rtl/bpq_pkg.sv
hw/rtl/bpq_min_scan.sv
hw/rtl/bucket_priority_queue_unit.sv
sim/bucket_priority_queue_unit_tb.sv
